@@ rtl/ofl_pkg.sv @@
// Shared types and constants for the overwrite-oldest frame log.
// No dependencies; compiled first.
package ofl_pkg;

    localparam int LOG_DEPTH_DEF = 64;
    localparam int FILL_W        = 7;
    localparam int LOST_W        = 32;

    localparam logic REQ_LOG  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic [7:0]  info_byte;
        logic [3:0]  length;
        logic [31:0] ident;
        logic [63:0] payload;
    } frame_t;

    typedef struct packed {
        logic              read_valid;
        logic [FILL_W-1:0] fill_level;
        logic [LOST_W-1:0] lost_frames;
    } status_t;

endpackage

@@ rtl/ofl_req_if.sv @@
// Request channel: valid/ready and one request beat.
// Depends on ofl_pkg.
interface ofl_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  in_info_byte;
    logic [3:0]  in_length;
    logic [31:0] in_ident;
    logic [63:0] in_payload;

    modport source (output valid, req_type, in_info_byte, in_length, in_ident, in_payload,
                    input ready);
    modport sink   (input valid, req_type, in_info_byte, in_length, in_ident, in_payload,
                    output ready);
endinterface

@@ rtl/ofl_rsp_if.sv @@
// Result channel: valid/ready and one result beat.
// Depends on ofl_pkg widths (written out here).
interface ofl_rsp_if;
    logic        valid;
    logic        ready;
    logic        read_valid;
    logic [7:0]  out_info_byte;
    logic [3:0]  out_length;
    logic [31:0] out_ident;
    logic [63:0] out_payload;
    logic [6:0]  fill_level;
    logic [31:0] lost_frames;

    modport source (output valid, read_valid, out_info_byte, out_length, out_ident,
                    out_payload, fill_level, lost_frames,
                    input ready);
    modport sink   (input valid, read_valid, out_info_byte, out_length, out_ident,
                    out_payload, fill_level, lost_frames,
                    output ready);
endinterface

@@ rtl/ofl_store.sv @@
// Frame memory: one write port, one read port with registered read data.
// Depends on ofl_pkg.
module ofl_store
    import ofl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int PTR_W     = $clog2(LOG_DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  frame_t           wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output frame_t           rd_data
);

    frame_t mem [LOG_DEPTH];
    frame_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ofl_ctrl.sv @@
// Ring control: pointers, fill count and saturating lost-frame counter.
// Depends on ofl_pkg.
module ofl_ctrl
    import ofl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int PTR_W     = $clog2(LOG_DEPTH),
    parameter int CNT_W     = $clog2(LOG_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             req_type,
    output logic             wr_en,
    output logic [PTR_W-1:0] wr_addr,
    output logic             rd_en,
    output logic [PTR_W-1:0] rd_addr,
    output status_t          status_next
);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [LOST_W-1:0] lost_reg, lost_next;
    logic              full, empty;
    logic [PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;

    assign full       = (held_reg == CNT_W'(LOG_DEPTH));
    assign empty      = (held_reg == '0);
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        held_next   = held_reg;
        lost_next   = lost_reg;
        if (accept)
        begin
            unique case (req_type)
                REQ_LOG:
                begin
                    wr_en       = 1'b1;
                    wr_ptr_next = wr_ptr_inc;
                    if (full)
                    begin
                        rd_ptr_next = rd_ptr_inc;
                        if (lost_reg != '1)
                        begin
                            lost_next = lost_reg + LOST_W'(1);
                        end
                    end
                    else
                    begin
                        held_next = held_reg + CNT_W'(1);
                    end
                end
                REQ_READ:
                begin
                    if (!empty)
                    begin
                        rd_en       = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                        held_next   = held_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign wr_addr                 = wr_ptr_reg;
    assign rd_addr                 = rd_ptr_reg;
    assign status_next.read_valid  = rd_en;
    assign status_next.fill_level  = FILL_W'(held_next);
    assign status_next.lost_frames = lost_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            held_reg   <= '0;
            lost_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            held_reg   <= held_next;
            lost_reg   <= lost_next;
        end
    end

endmodule

@@ rtl/overwrite_oldest_frame_log_core.sv @@
// Overwrite-oldest frame log, top level: handshake, result register, ring
// control and frame memory. Depends on ofl_pkg, ofl_req_if, ofl_rsp_if,
// ofl_ctrl and ofl_store.
//
//  channel | modport | beat
//  --------+---------+------------------------------------------------------
//  req     | sink    | req_type, in_info_byte, in_length, in_ident, in_payload
//  rsp     | source  | read_valid, out_* frame fields, fill_level, lost_frames
//
// One request per cycle while rsp is not stalled; each result appears in the
// cycle after its request. The single result register sets the figure: a request
// is taken whenever the register is empty or its beat is taken in the same cycle.
// Reset clears pointers, counts and the result valid; memory is not cleared.
// A stalled rsp holds its beat and stalls req through ready.
module overwrite_oldest_frame_log_core
    import ofl_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    ofl_req_if.sink  req,
    ofl_rsp_if.source rsp
);

    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);

    logic             accept;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    frame_t           wr_data, rd_data;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign wr_data.info_byte = req.in_info_byte;
    assign wr_data.length    = req.in_length;
    assign wr_data.ident     = req.in_ident;
    assign wr_data.payload   = req.in_payload;

    ofl_ctrl #(
        .LOG_DEPTH (LOG_DEPTH),
        .PTR_W     (PTR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req.req_type),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .status_next (status_next)
    );

    ofl_store #(
        .LOG_DEPTH (LOG_DEPTH),
        .PTR_W     (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    // frame fields read as zero unless a frame was returned
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_valid    = status_reg.read_valid;
    assign rsp.out_info_byte = status_reg.read_valid ? rd_data.info_byte : '0;
    assign rsp.out_length    = status_reg.read_valid ? rd_data.length    : '0;
    assign rsp.out_ident     = status_reg.read_valid ? rd_data.ident     : '0;
    assign rsp.out_payload   = status_reg.read_valid ? rd_data.payload   : '0;
    assign rsp.fill_level    = status_reg.fill_level;
    assign rsp.lost_frames   = status_reg.lost_frames;

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory write and read issued together");

    a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        status_next.read_valid |-> (accept && req.req_type == REQ_READ))
        else $error("frame returned without an accepted read");

    a_read_keeps_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_READ) |->
            (status_next.lost_frames == status_reg.lost_frames))
        else $error("lost count changed on a read");

    a_lost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (status_reg.lost_frames >= $past(status_reg.lost_frames)))
        else $error("lost count went down");

endmodule
